@@ rtl/dmix_pkg.sv @@
package dmix_pkg;

  // Position coding and deadzone limits
  localparam int unsigned PosW       = 7;
  localparam int unsigned SpeedW     = 8;
  localparam int unsigned ProdW      = 14;
  localparam logic [PosW-1:0] LowTop     = 7'd60;
  localparam logic [PosW-1:0] HighBase   = 7'd68;
  localparam logic [PosW-1:0] LowSpan    = 7'd62;
  localparam logic [PosW-1:0] PosNeutral = 7'd64;
  localparam logic [SpeedW-1:0] MaxSpeedReset = 8'd235;

  // Reciprocal constants: floor(n*M >> 20) == floor(n/d) for every product n < 2^14
  localparam int unsigned RecipShift = 20;
  localparam int unsigned RecipW     = 29;
  localparam logic [14:0] Recip62    = 15'd16913;
  localparam logic [14:0] Recip59    = 15'd17773;

  typedef enum logic [1:0] {
    ZONE_LOW,
    ZONE_NEUTRAL,
    ZONE_HIGH
  } zone_e;

  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_CW  = 2'd1,
    DIR_CCW = 2'd2
  } dir_e;

  // Zone and scaled numerator of one stick position
  typedef struct packed {
    zone_e            zone;
    logic [ProdW-1:0] prod;
  } span_t;

  // Divide the numerator by the span of its zone (62 low, 59 high)
  function automatic logic [SpeedW-1:0] span_mag(span_t s);
    logic [RecipW-1:0] p;
    if (s.zone == ZONE_LOW) begin
      p = RecipW'(s.prod) * RecipW'(Recip62);
    end else begin
      p = RecipW'(s.prod) * RecipW'(Recip59);
    end
    return SpeedW'(p >> RecipShift);
  endfunction

endpackage

@@ rtl/dmix_if.sv @@
// Command byte channel
interface dmix_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_byte;

  modport source (output valid, output command_byte, input ready);
  modport sink   (input valid, input command_byte, output ready);
endinterface

// Motor result channel
interface dmix_motor_if;
  logic       valid;
  logic       ready;
  logic [1:0] right_direction;
  logic [7:0] right_duty;
  logic [1:0] left_direction;
  logic [7:0] left_duty;

  modport source (output valid, output right_direction, output right_duty,
                  output left_direction, output left_duty, input ready);
  modport sink   (input valid, input right_direction, input right_duty,
                  input left_direction, input left_duty, output ready);
endinterface

// Configuration write channel
interface dmix_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_speed;

  modport source (output valid, output max_speed, input ready);
  modport sink   (input valid, input max_speed, output ready);
endinterface

@@ rtl/dmix_zone_map.sv @@
module dmix_zone_map (
  input  logic [dmix_pkg::PosW-1:0]   pos_i,
  input  logic [dmix_pkg::SpeedW-1:0] max_speed_i,
  output dmix_pkg::span_t             span_o
);
  import dmix_pkg::*;

  logic [5:0] gap;

  // Classify the position and take its distance from LowSpan (low) or HighBase (high)
  always_comb begin
    if (pos_i <= LowTop) begin
      span_o.zone = ZONE_LOW;
      gap         = 6'(LowSpan - pos_i);
    end else if (pos_i >= HighBase) begin
      span_o.zone = ZONE_HIGH;
      gap         = 6'(pos_i - HighBase);
    end else begin
      span_o.zone = ZONE_NEUTRAL;
      gap         = '0;
    end
    // Scale by full speed; the divide by the span follows a register later
    span_o.prod = ProdW'(gap) * ProdW'(max_speed_i);
  end

endmodule

@@ rtl/differential_drive_mixer.sv @@
// Differential-drive mixer.
// cmd_i takes one command byte per transfer: bit 7 clear loads bits 6..0 as
// the throttle position, bit 7 set loads them as the steering position.
// Every accepted byte yields exactly one transfer on res_o with direction
// and duty for the right and left motors, mixed from both stored positions.
// cfg_i writes max_speed (full scale and cap for added steering); write it
// only while no command is in flight. cfg_i is always ready.
// An accepted byte is registered in stage 1, stage 2 and stage 3 in turn
// and is valid on res_o from stage 3. Throughput is one byte per cycle
// while res_o is not stalled, set by a three-stage pipeline (positions,
// scaled numerators, mixed output) whose stages load independently.
// Reset sets both positions to neutral (64), max_speed to 235 and empties
// the pipeline. When the receiver stalls, the result holds on res_o and the
// stages behind it fill up; cmd_i.ready drops only once all three stages
// are occupied, so up to three bytes are taken during a stall.
module differential_drive_mixer (
  input  logic          clk_i,
  input  logic          rst_ni,
  dmix_cmd_if.sink      cmd_i,
  dmix_cfg_if.sink      cfg_i,
  dmix_motor_if.source  res_o
);
  import dmix_pkg::*;

  logic [SpeedW-1:0] max_speed_q;
  logic [PosW-1:0]   thr_q, thr_d, str_q, str_d;
  logic              v1_q, v2_q, v3_q;
  logic              en1, en2, en3, cmd_xfer;
  logic [PosW-1:0]   t1_q, s1_q;
  span_t             t_span, s_span, t2_q, s2_q;
  logic [SpeedW-1:0] tmag, smag;
  logic [SpeedW:0]   add_sum;
  logic [SpeedW-1:0] add_cap, sub_floor;
  logic              steer;
  dir_e              rdir_d, ldir_d, rdir_q, ldir_q;
  logic [SpeedW-1:0] rduty_d, lduty_d, rduty_q, lduty_q;

  // Stage enables: a stage loads when it is empty or its contents move on
  assign en3      = !v3_q || res_o.ready;
  assign en2      = !v2_q || en3;
  assign en1      = !v1_q || en2;
  assign cmd_i.ready = en1;
  assign cmd_xfer = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  // Update the stored position that the byte selects
  always_comb begin
    thr_d = thr_q;
    str_d = str_q;
    if (cmd_i.command_byte[7]) begin
      str_d = cmd_i.command_byte[PosW-1:0];
    end else begin
      thr_d = cmd_i.command_byte[PosW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MaxSpeedReset;
      thr_q       <= PosNeutral;
      str_q       <= PosNeutral;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        max_speed_q <= cfg_i.max_speed;
      end
      if (cmd_xfer) begin
        thr_q <= thr_d;
        str_q <= str_d;
      end
      if (en1) v1_q <= cmd_xfer;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: snapshot both positions for this byte
  always_ff @(posedge clk_i) begin
    if (en1 && cmd_xfer) begin
      t1_q <= thr_d;
      s1_q <= str_d;
    end
  end

  // Stage 2: zone and scaled numerator of each position
  dmix_zone_map u_thr_map (
    .pos_i       (t1_q),
    .max_speed_i (max_speed_q),
    .span_o      (t_span)
  );

  dmix_zone_map u_str_map (
    .pos_i       (s1_q),
    .max_speed_i (max_speed_q),
    .span_o      (s_span)
  );

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      t2_q <= t_span;
      s2_q <= s_span;
    end
  end

  // Stage 3: divide by the span, then mix the two sticks
  assign tmag      = span_mag(t2_q);
  assign smag      = span_mag(s2_q);
  assign steer     = (s2_q.zone != ZONE_NEUTRAL) && (smag != '0);
  assign add_sum   = (SpeedW+1)'(tmag) + (SpeedW+1)'(smag);
  assign add_cap   = (add_sum > (SpeedW+1)'(max_speed_q)) ? max_speed_q
                                                          : add_sum[SpeedW-1:0];
  assign sub_floor = (tmag > smag) ? tmag - smag : '0;

  always_comb begin
    rdir_d  = DIR_OFF;
    ldir_d  = DIR_OFF;
    rduty_d = '0;
    lduty_d = '0;
    if (t2_q.zone == ZONE_NEUTRAL) begin
      // Spin in place on steering alone
      if (steer) begin
        if (s2_q.zone == ZONE_LOW) begin
          rdir_d = DIR_CCW;
          ldir_d = DIR_CW;
        end else begin
          rdir_d = DIR_CW;
          ldir_d = DIR_CCW;
        end
        rduty_d = smag;
        lduty_d = smag;
      end
    end else begin
      // Both sides follow the throttle; steering slows one and speeds the other
      rdir_d  = (t2_q.zone == ZONE_LOW) ? DIR_CCW : DIR_CW;
      ldir_d  = rdir_d;
      rduty_d = tmag;
      lduty_d = tmag;
      if (steer) begin
        if (s2_q.zone == ZONE_LOW) begin
          rduty_d = sub_floor;
          lduty_d = add_cap;
        end else begin
          lduty_d = sub_floor;
          rduty_d = add_cap;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      rdir_q  <= rdir_d;
      ldir_q  <= ldir_d;
      rduty_q <= rduty_d;
      lduty_q <= lduty_d;
    end
  end

  assign res_o.valid           = v3_q;
  assign res_o.right_direction = rdir_q;
  assign res_o.right_duty      = rduty_q;
  assign res_o.left_direction  = ldir_q;
  assign res_o.left_duty       = lduty_q;

  // Motors off on one side means both sides off and idle
  a_off_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdir_q == DIR_OFF) |->
      (ldir_q == DIR_OFF && rduty_q == '0 && lduty_q == '0))
    else $error("one motor off while the other drives");

  // Opposite directions only in a spin, which runs both sides equally
  a_spin_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdir_q != ldir_q) |-> (rduty_q == lduty_q))
    else $error("spin with unequal duties");

  // A full pipeline under a stalled receiver takes no new byte
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !res_o.ready) |-> !cmd_i.ready)
    else $error("byte taken with the pipeline full");

endmodule
